>>> src/kcr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kcr_pkg: shared types and constants of the key2 candidate reduction block
// Holds the list memory geometry, register codes and the inverse CRC table.
// ----------------------------------------------------------------------------
package kcr_pkg;

    // Every key3 value owns a list of exactly this many 14-bit low values.
    localparam int LIST_LEN   = 64;
    localparam int LIST_IDX_W = 6;
    localparam int KEY_W      = 8;
    // List entries hold v >> 2, since bits 1..0 of every value are zero.
    localparam int VAL_W      = 14;
    localparam int ADDR_W     = KEY_W + LIST_IDX_W;
    localparam int DEPTH      = 1 << ADDR_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY3_CUR    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY3_PREV   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMON_MASK = 2'd2;

    localparam logic [15:0] MASK_RESET = 16'hfc00;
    localparam logic [31:0] HI_MASK    = 32'hfffffc00;
    localparam logic [31:0] CRC_POLY   = 32'hedb88320;

    typedef struct packed {
        logic [KEY_W-1:0] key3_cur;
        logic [KEY_W-1:0] key3_prev;
        logic [15:0]      common_mask;
    } cfg_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [VAL_W-1:0]  data;
    } list_wr_t;

    typedef logic [31:0] crc_table_t [256];

    // Inverse CRC-32 table: the forward word of byte b is filed under its
    // top byte, holding (crc << 8) ^ b. Evaluated at elaboration only.
    function automatic crc_table_t build_crc_inv();
        crc_table_t  tab;
        logic [31:0] t;
        for (int b = 0; b < 256; b++) begin
            t = 32'(b);
            for (int k = 0; k < 8; k++) begin
                t = t[0] ? ((t >> 1) ^ CRC_POLY) : (t >> 1);
            end
            tab[t[31:24]] = (t << 8) ^ 32'(b);
        end
        return tab;
    endfunction

    localparam crc_table_t CRC_INV = build_crc_inv();

endpackage
`default_nettype wire

>>> src/kcr_list_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kcr_list_mem: low-bits list memory
// One write port for the fill pass and one registered read port for the scan.
// ----------------------------------------------------------------------------
module kcr_list_mem (
    input  wire                       aclk,
    input  kcr_pkg::list_wr_t         wr,
    input  wire [kcr_pkg::ADDR_W-1:0] rd_addr,
    output logic [kcr_pkg::VAL_W-1:0] rd_data
);

    logic [kcr_pkg::VAL_W-1:0] mem [kcr_pkg::DEPTH];
    logic [kcr_pkg::VAL_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

>>> src/kcr_fill.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kcr_fill: builds the low-bits lists after reset
// Sweeps every value v = 4k, sorts it into the list of its key3 byte with a
// per-list fill count kept in a small memory.
// ----------------------------------------------------------------------------
module kcr_fill (
    input  wire                aclk,
    input  wire                aresetn,
    output kcr_pkg::list_wr_t  wr,
    output logic               done
);

    localparam int KW = kcr_pkg::KEY_W;
    localparam int IW = kcr_pkg::LIST_IDX_W;
    localparam int VW = kcr_pkg::VAL_W;

    logic          issue_reg;
    logic [VW-1:0] vc_reg;
    logic          vld_s1_reg;
    logic          vld_s2_reg;
    logic          wr_vld_reg;
    logic          done_reg;
    logic [(1 << KW)-1:0] cnt_vld_reg;

    logic [KW-1:0] key_s1_reg;
    logic [VW-1:0] vc_s1_reg;
    logic [KW-1:0] key_s2_reg;
    logic [VW-1:0] vc_s2_reg;
    logic          cvld_s2_reg;
    logic [IW-1:0] cnt_rd_reg;
    logic [KW-1:0] wr_key_reg;
    logic [IW-1:0] wr_cnt_reg;

    logic [IW-1:0] cnt_mem [1 << KW];

    logic [15:0]   op_a;
    logic [15:0]   op_b;
    logic [31:0]   prod;
    logic [IW-1:0] cnt_eff;
    logic [IW-1:0] cnt_inc;

    assign op_a = {vc_reg, 2'b10};
    assign op_b = {vc_reg, 2'b11};
    assign prod = op_a * op_b;

    // The entry written on the previous edge was not yet visible to the read.
    always_comb begin
        if (wr_vld_reg && (wr_key_reg == key_s2_reg)) begin
            cnt_eff = wr_cnt_reg;
        end else if (cvld_s2_reg) begin
            cnt_eff = cnt_rd_reg;
        end else begin
            cnt_eff = '0;
        end
    end

    assign cnt_inc = cnt_eff + IW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_reg   <= 1'b1;
            vc_reg      <= '0;
            vld_s1_reg  <= 1'b0;
            vld_s2_reg  <= 1'b0;
            wr_vld_reg  <= 1'b0;
            done_reg    <= 1'b0;
            cnt_vld_reg <= '0;
        end else begin
            vld_s1_reg <= issue_reg;
            vld_s2_reg <= vld_s1_reg;
            wr_vld_reg <= vld_s2_reg;
            if (issue_reg) begin
                vc_reg <= vc_reg + VW'(1);
                if (vc_reg == '1) begin
                    issue_reg <= 1'b0;
                end
            end
            if (vld_s2_reg) begin
                cnt_vld_reg[key_s2_reg] <= 1'b1;
                if (vc_s2_reg == '1) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        key_s1_reg  <= prod[15:8];
        vc_s1_reg   <= vc_reg;
        key_s2_reg  <= key_s1_reg;
        vc_s2_reg   <= vc_s1_reg;
        cvld_s2_reg <= cnt_vld_reg[key_s1_reg];
        wr_key_reg  <= key_s2_reg;
        wr_cnt_reg  <= cnt_inc;
    end

    always_ff @(posedge aclk) begin
        if (vld_s2_reg) begin
            cnt_mem[key_s2_reg] <= cnt_inc;
        end
        cnt_rd_reg <= cnt_mem[key_s1_reg];
    end

    assign wr.we   = vld_s2_reg;
    assign wr.addr = {key_s2_reg, cnt_eff};
    assign wr.data = vc_s2_reg;
    assign done    = done_reg;

endmodule
`default_nettype wire

>>> src/kcr_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kcr_scan: list scan sequencer and result buffer
// Walks the key3_cur list and, for each hit, the key3_prev list, one entry
// per cycle barring output stalls, holding one result back to mark the last.
// ----------------------------------------------------------------------------
module kcr_scan #(
    parameter int MAX_RUN = 64
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  kcr_pkg::cfg_t              cfg,
    input  wire                        fill_done,
    input  wire                        s_valid,
    output logic                       s_ready,
    input  wire [31:0]                 s_key2_next,
    output logic                       m_valid,
    input  wire                        m_ready,
    output logic [31:0]                m_key2_cand,
    output logic                       m_last,
    output logic                       m_overflow,
    output logic [kcr_pkg::ADDR_W-1:0] rd_addr,
    input  wire [kcr_pkg::VAL_W-1:0]   rd_data
);

    localparam int IW  = kcr_pkg::LIST_IDX_W;
    localparam int KW  = kcr_pkg::KEY_W;
    localparam int N_W = $clog2(MAX_RUN + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_OUTER = 2'd1;
    localparam logic [1:0] ST_INNER = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0]     state_reg,    state_next;
    logic [IW-1:0]  idx_reg,      idx_next;
    logic [IW-1:0]  jdx_reg,      jdx_next;
    logic [N_W-1:0] n_reg,        n_next;
    logic           over_reg,     over_next;
    logic           pend_vld_reg, pend_vld_next;
    logic           m_vld_reg,    m_vld_next;

    logic [31:0]    upper_reg,    upper_next;
    logic [31:0]    cand_reg,     cand_next;
    logic [5:0]     rhs2_reg,     rhs2_next;
    logic [1:0]     xlow_reg,     xlow_next;
    logic [31:0]    pend_reg,     pend_next;
    logic [31:0]    m_cand_reg,   m_cand_next;
    logic           m_last_reg,   m_last_next;
    logic           m_over_reg,   m_over_next;

    logic [KW-1:0]  rd_key;
    logic [IW-1:0]  rd_idx;
    logic           out_free;
    logic [15:0]    v_full;
    logic           outer_hit;
    logic           inner_hit;
    logic [31:0]    cand_w;
    logic [31:0]    inv_w;
    logic [31:0]    up2_w;
    logic [31:0]    result_w;
    logic           run_full;
    logic           idx_last;
    logic           jdx_last;
    logic           stall;

    assign out_free  = !m_vld_reg || m_ready;
    assign v_full    = {rd_data, 2'b00};
    assign outer_hit = ((v_full ^ upper_reg[15:0]) & cfg.common_mask) == 16'h0000;
    assign cand_w    = (upper_reg & kcr_pkg::HI_MASK) | {16'h0000, v_full};
    assign inv_w     = kcr_pkg::CRC_INV[cand_w[31:24]];
    assign up2_w     = {cand_w[23:0], 8'h00} ^ inv_w;
    // Bits 13..8 of the stored entry (v_full bits 15..10) line up with rhs2;
    // bits 7..6 give the two low key2 bits after the second table lookup.
    assign inner_hit = rd_data[13:8] == rhs2_reg;
    assign result_w  = cand_reg | {30'h0, rd_data[7:6] ^ xlow_reg};
    assign run_full  = n_reg == N_W'(MAX_RUN);
    assign idx_last  = idx_reg == '1;
    assign jdx_last  = jdx_reg == '1;
    assign stall     = (state_reg == ST_INNER) && inner_hit && !run_full &&
                       pend_vld_reg && !out_free;

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        jdx_next      = jdx_reg;
        n_next        = n_reg;
        over_next     = over_reg;
        pend_vld_next = pend_vld_reg;
        pend_next     = pend_reg;
        upper_next    = upper_reg;
        cand_next     = cand_reg;
        rhs2_next     = rhs2_reg;
        xlow_next     = xlow_reg;
        m_vld_next    = m_vld_reg && !m_ready;
        m_cand_next   = m_cand_reg;
        m_last_next   = m_last_reg;
        m_over_next   = m_over_reg;
        rd_key        = cfg.key3_cur;
        rd_idx        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && fill_done) begin
                    upper_next = {s_key2_next[23:0], 8'h00} ^
                                 kcr_pkg::CRC_INV[s_key2_next[31:24]];
                    idx_next   = '0;
                    n_next     = '0;
                    over_next  = 1'b0;
                    state_next = ST_OUTER;
                end
            end
            ST_OUTER: begin
                if (outer_hit) begin
                    cand_next  = cand_w;
                    rhs2_next  = up2_w[15:10];
                    xlow_next  = inv_w[9:8];
                    jdx_next   = '0;
                    state_next = ST_INNER;
                    rd_key     = cfg.key3_prev;
                end else if (idx_last) begin
                    state_next = ST_FLUSH;
                end else begin
                    idx_next = idx_reg + IW'(1);
                    rd_idx   = idx_reg + IW'(1);
                end
            end
            ST_INNER: begin
                if (stall) begin
                    rd_key = cfg.key3_prev;
                    rd_idx = jdx_reg;
                end else if (inner_hit && run_full) begin
                    over_next  = 1'b1;
                    state_next = ST_FLUSH;
                end else begin
                    if (inner_hit) begin
                        if (pend_vld_reg) begin
                            m_vld_next  = 1'b1;
                            m_cand_next = pend_reg;
                            m_last_next = 1'b0;
                            m_over_next = 1'b0;
                        end
                        pend_vld_next = 1'b1;
                        pend_next     = result_w;
                        n_next        = n_reg + N_W'(1);
                    end
                    if (!jdx_last) begin
                        jdx_next = jdx_reg + IW'(1);
                        rd_key   = cfg.key3_prev;
                        rd_idx   = jdx_reg + IW'(1);
                    end else if (!idx_last) begin
                        idx_next   = idx_reg + IW'(1);
                        rd_idx     = idx_reg + IW'(1);
                        state_next = ST_OUTER;
                    end else begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_vld_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_vld_next    = 1'b1;
                    m_cand_next   = pend_reg;
                    m_last_next   = 1'b1;
                    m_over_next   = over_reg;
                    pend_vld_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            jdx_reg      <= '0;
            n_reg        <= '0;
            over_reg     <= 1'b0;
            pend_vld_reg <= 1'b0;
            m_vld_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            jdx_reg      <= jdx_next;
            n_reg        <= n_next;
            over_reg     <= over_next;
            pend_vld_reg <= pend_vld_next;
            m_vld_reg    <= m_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        upper_reg  <= upper_next;
        cand_reg   <= cand_next;
        rhs2_reg   <= rhs2_next;
        xlow_reg   <= xlow_next;
        pend_reg   <= pend_next;
        m_cand_reg <= m_cand_next;
        m_last_reg <= m_last_next;
        m_over_reg <= m_over_next;
    end

    assign rd_addr     = {rd_key, rd_idx};
    assign s_ready     = (state_reg == ST_IDLE) && fill_done;
    assign m_valid     = m_vld_reg;
    assign m_key2_cand = m_cand_reg;
    assign m_last      = m_last_reg;
    assign m_overflow  = m_over_reg;

endmodule
`default_nettype wire

>>> src/key2_candidate_reduction.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// key2_candidate_reduction: one key2 reduction step of the PKZIP key attack
// Takes a key2 candidate of position i+1 and returns up to MAX_RUN fitting
// key2 candidates of position i, in list order, with the final beat marked.
// ----------------------------------------------------------------------------
// After reset the block builds its 16384-entry low-bits list memory, sweeping
// one value per cycle; s_ready stays low while this fill pass runs, and
// configuration writes are taken during it as ever. Each input beat undoes
// one CRC step, then scans the 64-entry list of key3_cur and, for every entry
// whose masked bits agree, the 64-entry list of key3_prev. The list memory
// has one read port, so the scan reads one list entry per cycle except while
// a full output register holds it; a run that overflows ends its scan early.
// Results leave through an output register while one more result waits in a
// holding register, which lets the final beat of a run carry last, and
// overflow when more than MAX_RUN candidates were found. An input that yields
// no candidate produces no beat. Configuration is written through cfg_we,
// cfg_index and cfg_wdata: index 0 is key3_cur, 1 is key3_prev, 2 is
// common_mask, and index 3 is ignored.
// ----------------------------------------------------------------------------
module key2_candidate_reduction #(
    parameter int MAX_RUN = 64
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            cfg_we,
    input  wire [kcr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire [kcr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire                            s_valid,
    output logic                           s_ready,
    input  wire [31:0]                     s_key2_next,
    output logic                           m_valid,
    input  wire                            m_ready,
    output logic [31:0]                    m_key2_cand,
    output logic                           m_last,
    output logic                           m_overflow
);

    // Configuration registers; the whole block reads them as one bundle.
    kcr_pkg::cfg_t cfg_reg;

    kcr_pkg::list_wr_t            list_wr;
    logic                         fill_done;
    logic [kcr_pkg::ADDR_W-1:0]   rd_addr;
    logic [kcr_pkg::VAL_W-1:0]    rd_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.key3_cur    <= '0;
            cfg_reg.key3_prev   <= '0;
            cfg_reg.common_mask <= kcr_pkg::MASK_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                kcr_pkg::CFG_KEY3_CUR: begin
                    cfg_reg.key3_cur <= cfg_wdata[kcr_pkg::KEY_W-1:0];
                end
                kcr_pkg::CFG_KEY3_PREV: begin
                    cfg_reg.key3_prev <= cfg_wdata[kcr_pkg::KEY_W-1:0];
                end
                kcr_pkg::CFG_COMMON_MASK: begin
                    cfg_reg.common_mask <= cfg_wdata;
                end
                default: begin
                    // Writes beyond the register list have no effect.
                end
            endcase
        end
    end

    // The fill sequencer owns the write port until the lists are complete.
    kcr_fill u_fill (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (list_wr),
        .done    (fill_done)
    );

    kcr_list_mem u_list_mem (
        .aclk    (aclk),
        .wr      (list_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // The scan issues one read address per cycle and sees its data on the
    // next cycle, so the entry it compares is always the one it asked for.
    kcr_scan #(
        .MAX_RUN (MAX_RUN)
    ) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .fill_done   (fill_done),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_key2_next (s_key2_next),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_key2_cand (m_key2_cand),
        .m_last      (m_last),
        .m_overflow  (m_overflow),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data)
    );

endmodule
`default_nettype wire

>>> src/kcr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kcr_port_checker: port-level checks of the key2 candidate reduction block
// Watches the handshakes and the run markers over time.
// ----------------------------------------------------------------------------
module kcr_port_checker (
    input wire                            aclk,
    input wire                            aresetn,
    input wire                            cfg_we,
    input wire [kcr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input wire [kcr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input wire                            s_valid,
    input wire                            s_ready,
    input wire [31:0]                     s_key2_next,
    input wire                            m_valid,
    input wire                            m_ready,
    input wire [31:0]                     m_key2_cand,
    input wire                            m_last,
    input wire                            m_overflow
);

    logic [50:0] watch_bus;
    assign watch_bus = {cfg_we, cfg_index, cfg_wdata, s_key2_next};

    // A held result beat keeps its contents until it is taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid &&
            $stable({m_key2_cand, m_last, m_overflow}))
        else $error("result beat changed while stalled");

    // Overflow is only reported on the final beat of a run.
    a_over_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflow |-> m_last)
        else $error("overflow on a beat that is not last");

    // While a run is still producing beats, no new input is taken.
    a_busy_mid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !s_ready)
        else $error("input ready in the middle of a run");

    // An accepted input always occupies the block for the next cycle.
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (watch_bus == watch_bus) |=> !s_ready)
        else $error("input ready right after an accepted beat");

endmodule

bind key2_candidate_reduction kcr_port_checker u_kcr_checker (.*);
`default_nettype wire
